// ===== design/bls_pkg.sv =====
`timescale 1ns / 1ps

package bls_pkg;

	// default geometry
	localparam int COORD_BITS_DEF = 16;
	localparam int CANVAS_DEF     = 1024;

	// action codes of an input word
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	// direction of the minor axis step
	typedef enum logic [1:0] {
		MINOR_NONE = 2'd0,
		MINOR_POS  = 2'd1,
		MINOR_NEG  = 2'd2
	} minor_dir_t;

	// per-pixel flags handed from the stepper to the output register
	typedef struct packed {
		logic visible;
		logic last;
	} pix_flags_t;

endpackage

// ===== design/bls_in_if.sv =====
`timescale 1ns / 1ps

interface bls_in_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source (
		output valid, action, start_x, start_y, end_x, end_y,
		input  ready
	);

	modport sink (
		input  valid, action, start_x, start_y, end_x, end_y,
		output ready
	);
endinterface

// ===== design/bls_out_if.sv =====
`timescale 1ns / 1ps

interface bls_out_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         visible;
	logic                         last;

	modport source (
		output valid, pixel_x, pixel_y, visible, last,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, visible, last,
		output ready
	);
endinterface

// ===== design/bls_core.sv =====
`timescale 1ns / 1ps

module bls_core
	import bls_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int CANVAS     = CANVAS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  action,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic                  emit,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output pix_flags_t            flags
);

	localparam int MW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 2;
	localparam logic [32:0] CANVAS_LIM = 33'(CANVAS);

	logic [COORD_BITS-1:0] cur_x_q;
	logic [COORD_BITS-1:0] cur_y_q;
	logic [EW-1:0]         err_q;
	logic [MW-1:0]         left_q;
	logic [MW-1:0]         major_q;
	logic [MW-1:0]         minor_q;
	logic                  major_is_x_q;
	logic                  major_neg_q;
	minor_dir_t            minor_dir_q;
	logic                  busy_q;

	logic [MW-1:0]         dx;
	logic [MW-1:0]         dy;
	logic [MW-1:0]         ax;
	logic [MW-1:0]         ay;
	logic                  ld_major_is_x;
	logic [MW-1:0]         ld_major;
	logic [MW-1:0]         ld_minor;
	logic                  ld_major_neg;
	logic [MW-1:0]         ld_minor_delta;
	minor_dir_t            ld_minor_dir;

	logic                  take_minor;
	logic [COORD_BITS-1:0] major_step;
	logic [COORD_BITS-1:0] minor_step;
	logic [COORD_BITS-1:0] nx_x;
	logic [COORD_BITS-1:0] nx_y;
	logic [EW-1:0]         nx_err;
	logic [MW-1:0]         nx_left;

	// endpoint deltas and their magnitudes
	always_comb begin
		dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
		dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
		ax = dx[MW-1] ? (~dx + 1'b1) : dx;
		ay = dy[MW-1] ? (~dy + 1'b1) : dy;
	end

	// driving axis, tie goes to y
	always_comb begin
		ld_major_is_x = ax > ay;
		if (ld_major_is_x) begin
			ld_major       = ax;
			ld_minor       = ay;
			ld_major_neg   = dx[MW-1];
			ld_minor_delta = dy;
		end else begin
			ld_major       = ay;
			ld_minor       = ax;
			ld_major_neg   = dy[MW-1];
			ld_minor_delta = dx;
		end
		if (ld_minor_delta == '0) begin
			ld_minor_dir = MINOR_NONE;
		end else if (ld_minor_delta[MW-1]) begin
			ld_minor_dir = MINOR_NEG;
		end else begin
			ld_minor_dir = MINOR_POS;
		end
	end

	// pixel out of the current position
	always_comb begin
		emit          = (action == ACT_ADVANCE) && busy_q;
		pixel_x       = cur_x_q;
		pixel_y       = cur_y_q;
		flags.visible = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1] &&
				(33'(cur_x_q) < CANVAS_LIM) && (33'(cur_y_q) < CANVAS_LIM);
		flags.last    = (left_q == MW'(1));
	end

	// one bresenham step
	always_comb begin
		take_minor = !err_q[EW-1];
		major_step = major_neg_q ? '1 : COORD_BITS'(1);
		unique case (minor_dir_q)
			MINOR_POS: minor_step = COORD_BITS'(1);
			MINOR_NEG: minor_step = '1;
			default:   minor_step = '0;
		endcase
		nx_x = cur_x_q;
		nx_y = cur_y_q;
		if (major_is_x_q) begin
			nx_x = cur_x_q + major_step;
			if (take_minor) begin
				nx_y = cur_y_q + minor_step;
			end
		end else begin
			nx_y = cur_y_q + major_step;
			if (take_minor) begin
				nx_x = cur_x_q + minor_step;
			end
		end
		nx_err  = err_q + {1'b0, minor_q} - (take_minor ? {1'b0, major_q} : '0);
		nx_left = left_q - 1'b1;
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			err_q        <= '0;
			left_q       <= '0;
			major_q      <= '0;
			minor_q      <= '0;
			major_is_x_q <= 1'b0;
			major_neg_q  <= 1'b0;
			minor_dir_q  <= MINOR_NONE;
			busy_q       <= 1'b0;
		end else if (en) begin
			if (action == ACT_LOAD) begin
				cur_x_q      <= start_x;
				cur_y_q      <= start_y;
				err_q        <= {1'b0, ld_minor} - {1'b0, ld_major};
				left_q       <= ld_major + 1'b1;
				major_q      <= ld_major;
				minor_q      <= ld_minor;
				major_is_x_q <= ld_major_is_x;
				major_neg_q  <= ld_major_neg;
				minor_dir_q  <= ld_minor_dir;
				busy_q       <= 1'b1;
			end else if (busy_q) begin
				cur_x_q <= nx_x;
				cur_y_q <= nx_y;
				err_q   <= nx_err;
				left_q  <= nx_left;
				busy_q  <= (nx_left != '0);
			end
		end
	end

endmodule

// ===== design/bresenham_line_stepper.sv =====
`timescale 1ns / 1ps

// Line rasterizer with a valid/ready word channel in (req) and out (rsp).
// A req word with action load latches two signed endpoints and produces
// no rsp word. Each req word with action advance, while a line is open,
// produces one rsp word: the current pixel, a visible flag for the square
// canvas [0, CANVAS) on both axes, and last on the final pixel. The line
// runs from start to end inclusive, major length plus one pixels. An
// advance with no open line is dropped; a load mid-line restarts at once.
// A pixel goes from the input register, through the stepping logic, into
// the output register, which drives rsp. Throughput: one req word per
// cycle while rsp does not stall, set by the single stepping stage whose
// add, compare and increment update the line state for each word taken.
// The output register takes a new pixel in the cycle the old one leaves.
// When rsp stalls, the pixel waits in the output register, an advance
// word that would produce a pixel waits in the input register, and
// req.ready drops until rsp moves on; words that make no pixel pass on.
// Reset clears the line state (no open line) and empties both registers.

module bresenham_line_stepper
	import bls_pkg::*;
#(
	parameter int CANVAS     = CANVAS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bls_in_if.sink    req,
	bls_out_if.source rsp
);

	logic                  valid_s1;
	logic                  action_s1;
	logic [COORD_BITS-1:0] start_x_s1;
	logic [COORD_BITS-1:0] start_y_s1;
	logic [COORD_BITS-1:0] end_x_s1;
	logic [COORD_BITS-1:0] end_y_s1;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] pixel_x_q;
	logic [COORD_BITS-1:0] pixel_y_q;
	pix_flags_t            flags_q;

	logic                  emit;
	logic                  out_free;
	logic                  proceed;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	pix_flags_t            flags;

	// flow control
	assign out_free  = !out_valid_q || rsp.ready;
	assign proceed   = valid_s1 && (!emit || out_free);
	assign req.ready = !valid_s1 || proceed;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1  <= req.action;
			start_x_s1 <= req.start_x;
			start_y_s1 <= req.start_y;
			end_x_s1   <= req.end_x;
			end_y_s1   <= req.end_y;
		end
	end

	bls_core #(
		.COORD_BITS (COORD_BITS),
		.CANVAS     (CANVAS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (proceed),
		.action  (action_s1),
		.start_x (start_x_s1),
		.start_y (start_y_s1),
		.end_x   (end_x_s1),
		.end_y   (end_y_s1),
		.emit    (emit),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.flags   (flags)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed && emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && emit) begin
			pixel_x_q <= pixel_x;
			pixel_y_q <= pixel_y;
			flags_q   <= flags;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.pixel_x = pixel_x_q;
	assign rsp.pixel_y = pixel_y_q;
	assign rsp.visible = flags_q.visible;
	assign rsp.last    = flags_q.last;

endmodule

// ===== design/bls_checker.sv =====
`timescale 1ns / 1ps

module bls_checker #(
	parameter int COORD_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [COORD_BITS-1:0] rsp_pixel_x,
	input logic [COORD_BITS-1:0] rsp_pixel_y,
	input logic                  rsp_visible,
	input logic                  rsp_last
);

	// a stalled pixel word stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) &&
			$stable(rsp_pixel_y) && $stable(rsp_visible) && $stable(rsp_last))
	else $error("rsp word changed while stalled");

	// with the output register empty, req is never held off
	assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
	else $error("req stalled with empty output register");

	// visible pixels never have negative coordinates
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_visible |->
			!rsp_pixel_x[COORD_BITS-1] && !rsp_pixel_y[COORD_BITS-1])
	else $error("visible pixel with negative coordinate");

	// nothing on rsp right after reset releases
	assert property (@(posedge clk)
		!$past(arst_n) |-> !rsp_valid)
	else $error("rsp valid right after reset");

endmodule

bind bresenham_line_stepper bls_checker #(
	.COORD_BITS (COORD_BITS)
) u_bls_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_pixel_x (rsp.pixel_x),
	.rsp_pixel_y (rsp.pixel_y),
	.rsp_visible (rsp.visible),
	.rsp_last    (rsp.last)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import bls_pkg::*;

	localparam int CANVAS = CANVAS_DEF;

	typedef struct packed {
		logic              action;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
	} line_word_t;

	localparam int WORD_W = $bits(line_word_t);

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               visible;
		logic               last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bls_in_if #(.COORD_BITS(16)) req_if ();
	bls_out_if #(.COORD_BITS(16)) rsp_if ();

	bresenham_line_stepper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// predicted line state
	logic signed [15:0] pos_x, pos_y;
	logic signed [17:0] err_acc;
	logic [16:0]        remaining, major_mag, minor_mag;
	logic               along_x, major_down;
	minor_dir_t         minor_step;
	bit                 line_open;

	pixel_t pixel_q[$];
	int     useful_words;
	int     mismatch_cnt = 0;
	bit     tx_idle = 1'b1;
	bit     rx_idle = 1'b1;

	always #4 clk = ~clk;

	// expected pixel for one accepted word, if any
	function void rasterize_word(line_word_t w);
		logic signed [16:0] dx, dy, md;
		logic [16:0]        ax, ay;
		pixel_t             px;
		if (w.action == ACT_LOAD) begin
			dx = {w.ex[15], w.ex} - {w.sx[15], w.sx};
			dy = {w.ey[15], w.ey} - {w.sy[15], w.sy};
			ax = dx[16] ? -dx : dx;
			ay = dy[16] ? -dy : dy;
			pos_x = w.sx;
			pos_y = w.sy;
			along_x = ax > ay;
			major_mag = along_x ? ax : ay;
			minor_mag = along_x ? ay : ax;
			major_down = along_x ? dx[16] : dy[16];
			md = along_x ? dy : dx;
			if (md == 0)
				minor_step = MINOR_NONE;
			else if (md[16])
				minor_step = MINOR_NEG;
			else
				minor_step = MINOR_POS;
			err_acc = {1'b0, minor_mag} - {1'b0, major_mag};
			remaining = major_mag + 17'd1;
			line_open = 1'b1;
			useful_words++;
		end else if (line_open) begin
			px.x = pos_x;
			px.y = pos_y;
			px.visible = pos_x >= 0 && pos_x < CANVAS && pos_y >= 0 && pos_y < CANVAS;
			px.last = remaining == 17'd1;
			pixel_q.insert(pixel_q.size(), px);
			// minor step when the error has reached zero
			if (!err_acc[17]) begin
				if (minor_step != MINOR_NONE) begin
					if (along_x)
						pos_y = (minor_step == MINOR_NEG) ? pos_y - 16'sd1 : pos_y + 16'sd1;
					else
						pos_x = (minor_step == MINOR_NEG) ? pos_x - 16'sd1 : pos_x + 16'sd1;
				end
				err_acc = err_acc - {1'b0, major_mag};
			end
			err_acc = err_acc + {1'b0, minor_mag};
			if (along_x)
				pos_x = major_down ? pos_x - 16'sd1 : pos_x + 16'sd1;
			else
				pos_y = major_down ? pos_y - 16'sd1 : pos_y + 16'sd1;
			remaining = remaining - 17'd1;
			if (remaining == 0)
				line_open = 1'b0;
			useful_words++;
		end
	endfunction

	function automatic int clamp_coord(int v);
		return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
	endfunction

	// drive one word at the falling edge and hold it until taken
	task automatic send_word(line_word_t w);
		while (tx_idle && $urandom_range(99) < 13) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid   = 1'b1;
		req_if.action  = w.action;
		req_if.start_x = w.sx;
		req_if.start_y = w.sy;
		req_if.end_x   = w.ex;
		req_if.end_y   = w.ey;
		do
			@(posedge clk);
		while (!req_if.ready);
		rasterize_word(w);
		@(negedge clk);
		req_if.valid = 1'b0;
	endtask

	task automatic send_load(int sx, int sy, int ex, int ey);
		line_word_t w;
		w.action = ACT_LOAD;
		w.sx = sx[15:0];
		w.sy = sy[15:0];
		w.ex = ex[15:0];
		w.ey = ey[15:0];
		send_word(w);
	endtask

	// advance words carry junk in the coordinate fields
	task automatic send_advance(int n);
		line_word_t w;
		repeat (n) begin
			w = line_word_t'(WORD_W'({$urandom(), $urandom(), $urandom()}));
			w.action = ACT_ADVANCE;
			send_word(w);
		end
	endtask

	// one line with random endpoints, mostly run to its end
	task automatic random_line();
		int r, sx, sy, ex, ey, span, pix, n, m;
		r = $urandom_range(99);
		span = 24;
		if (r < 70) begin
			sx = int'($urandom_range(1040)) - 16;
			sy = int'($urandom_range(1040)) - 16;
		end else begin
			sx = int'($urandom_range(65535)) - 32768;
			sy = int'($urandom_range(65535)) - 32768;
		end
		if (r >= 90) begin
			ex = int'($urandom_range(65535)) - 32768;
			ey = int'($urandom_range(65535)) - 32768;
		end else begin
			if (r >= 60 && r < 66)
				span = 150;
			ex = clamp_coord(sx + int'($urandom_range(2 * span)) - span);
			ey = clamp_coord(sy + int'($urandom_range(2 * span)) - span);
		end
		pix = (ex > sx) ? ex - sx : sx - ex;
		if (((ey > sy) ? ey - sy : sy - ey) > pix)
			pix = (ey > sy) ? ey - sy : sy - ey;
		pix++;
		m = $urandom_range(99);
		if (m < 80)
			n = pix;
		else if (m < 90)
			n = $urandom_range(pix - 1);
		else
			n = pix + $urandom_range(1, 3);
		if (r >= 90)
			n = $urandom_range(8);
		send_load(sx, sy, ex, ey);
		send_advance(n);
	endtask

	// idle advance, clipping edges, steep lines, restart mid-line
	task automatic test_directed_shapes();
		send_advance(1);
		send_load(1021, 1023, 1025, 1022);
		send_advance(6);
		send_load(0, 1, -1, -2);
		send_advance(4);
		send_load(10, 10, 20, 14);
		send_advance(2);
		send_load(3, 3, 0, 0);
		send_advance(4);
	endtask

	// full-range endpoints and a zero-length line
	task automatic test_extremes();
		send_load(-32768, 32767, 32767, -32768);
		send_advance(2);
		send_load(32767, -32768, -32768, 32767);
		send_advance(1);
		send_load(32767, -32768, 32767, -32768);
		send_advance(2);
	endtask

	// sender holds off until every pixel is out
	task automatic test_drain_pause();
		repeat (3) begin
			random_line();
			while (pixel_q.size() != 0)
				@(negedge clk);
		end
	endtask

	task automatic test_random_lines(int n_words);
		int goal;
		line_word_t w;
		goal = useful_words + n_words;
		while (useful_words < goal) begin
			if ($urandom_range(99) < 5) begin
				// stray word with random content
				w = line_word_t'(WORD_W'({$urandom(), $urandom(), $urandom()}));
				send_word(w);
			end else begin
				random_line();
			end
		end
	endtask

	// sink side stalls
	always @(negedge clk)
		rsp_if.ready = !rx_idle || ($urandom_range(99) >= 13);

	// compare each pixel word with the oldest prediction
	always @(posedge clk) begin
		pixel_t exp_px;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pixel_q.size() == 0) begin
				$error("unexpected pixel word x=%0d y=%0d", rsp_if.pixel_x, rsp_if.pixel_y);
				mismatch_cnt++;
			end else begin
				exp_px = pixel_q.pop_front();
				if (rsp_if.pixel_x !== exp_px.x) begin
					$error("pixel_x: expected %0d, got %0d", exp_px.x, rsp_if.pixel_x);
					mismatch_cnt++;
				end
				if (rsp_if.pixel_y !== exp_px.y) begin
					$error("pixel_y: expected %0d, got %0d", exp_px.y, rsp_if.pixel_y);
					mismatch_cnt++;
				end
				if (rsp_if.visible !== exp_px.visible) begin
					$error("visible: expected %0b, got %0b", exp_px.visible, rsp_if.visible);
					mismatch_cnt++;
				end
				if (rsp_if.last !== exp_px.last) begin
					$error("last: expected %0b, got %0b", exp_px.last, rsp_if.last);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		req_if.valid   = 1'b0;
		req_if.action  = ACT_LOAD;
		req_if.start_x = '0;
		req_if.start_y = '0;
		req_if.end_x   = '0;
		req_if.end_y   = '0;
		pos_x = '0;
		pos_y = '0;
		err_acc = '0;
		remaining = '0;
		major_mag = '0;
		minor_mag = '0;
		along_x = 1'b0;
		major_down = 1'b0;
		minor_step = MINOR_NONE;
		line_open = 1'b0;
		useful_words = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_shapes();
		test_extremes();
		test_drain_pause();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		test_random_lines(300);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		test_random_lines(1500);

		// let the pipeline empty
		while (pixel_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatch_cnt == 0 && pixel_q.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
